[rtl/mgd_pkg.sv]
// Shared types and constants of the motion gesture detector.
// Used by mgd_fifo, mgd_front, mgd_back and motion_gesture_detector; no dependencies.
package mgd_pkg;

  localparam int THR_W   = 12;
  localparam int HOLD_W  = 16;
  localparam int GAIN_W  = 8;
  localparam int MOVE_W  = 21;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 16;

  // Event queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QAW     = 2;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] REG_THR_LEFT   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_THR_RIGHT  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_THR_UP     = 3'd2;
  localparam logic [CFG_IW-1:0] REG_THR_DOWN   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_HOLD_SHORT = 3'd4;
  localparam logic [CFG_IW-1:0] REG_HOLD_LONG  = 3'd5;
  localparam logic [CFG_IW-1:0] REG_MOVE_GAIN  = 3'd6;
  localparam logic [CFG_IW-1:0] REG_MOVE_MODE  = 3'd7;

  // Reset values of the configuration registers
  localparam logic [THR_W-1:0]  RST_THR_X      = 12'd24;
  localparam logic [THR_W-1:0]  RST_THR_Y      = 12'd20;
  localparam logic [HOLD_W-1:0] RST_HOLD_SHORT = 16'd5;
  localparam logic [HOLD_W-1:0] RST_HOLD_LONG  = 16'd15;
  localparam logic [GAIN_W-1:0] RST_MOVE_GAIN  = 8'd1;

  // Hold-off counter slots
  localparam int CNT_LEFT  = 0;
  localparam int CNT_RIGHT = 1;
  localparam int CNT_UP    = 2;
  localparam int CNT_DOWN  = 3;

  // Event actions and directions
  localparam logic       ACT_PRESS   = 1'b0;
  localparam logic       ACT_RELEASE = 1'b1;
  localparam logic [1:0] DIR_LEFT    = 2'd0;
  localparam logic [1:0] DIR_RIGHT   = 2'd1;
  localparam logic [1:0] DIR_UP      = 2'd2;
  localparam logic [1:0] DIR_DOWN    = 2'd3;

  // Event slots within one frame, in emission order
  localparam logic [1:0] SLOT_X_PRESS   = 2'd0;
  localparam logic [1:0] SLOT_X_RELEASE = 2'd1;
  localparam logic [1:0] SLOT_Y_PRESS   = 2'd2;
  localparam logic [1:0] SLOT_Y_RELEASE = 2'd3;

  localparam logic [MOVE_W-1:0] NO_MOVE = '1;

  typedef struct packed {
    logic [THR_W-1:0]  thr_left;
    logic [THR_W-1:0]  thr_right;
    logic [THR_W-1:0]  thr_up;
    logic [THR_W-1:0]  thr_down;
    logic [HOLD_W-1:0] hold_short;
    logic [HOLD_W-1:0] hold_long;
    logic [GAIN_W-1:0] move_gain;
    logic              move_mode;
  } cfg_t;

  // Per-frame event descriptor; slot_mask bit i enables event slot i
  typedef struct packed {
    logic [3:0] slot_mask;
    logic       x_right;
    logic       y_down;
    logic       key_mode;
  } ev_ctl_t;

  localparam int CTL_W = $bits(ev_ctl_t);

endpackage

[rtl/mgd_fifo.sv]
// Short event queue that decouples the frame classifier from the event drain.
// Depends on mgd_pkg for the queue depth.
module mgd_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  input  logic         pop_i,
  output logic [W-1:0] head_o,
  output logic         full_o,
  output logic         empty_o
);
  import mgd_pkg::*;

  logic [W-1:0]   mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAW:0]   count_q, count_d;

  assign full_o  = (count_q == (QAW+1)'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries; no reset on payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/mgd_front.sv]
// Frame classifier: hold-off counters, delta tracking and direction tests.
// Depends on mgd_pkg; pushes one descriptor per frame with detections.
module mgd_front #(
  parameter int POS_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mgd_pkg::cfg_t                cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [POS_BITS:0]     pos_x_i,
  input  logic signed [POS_BITS:0]     pos_y_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output mgd_pkg::ev_ctl_t             push_ctl_o,
  output logic signed [POS_BITS+1:0]   push_dx_o,
  output logic signed [POS_BITS+1:0]   push_dy_o
);
  import mgd_pkg::*;

  localparam int PW = POS_BITS + 1;
  localparam int DW = POS_BITS + 2;
  localparam int CW = (DW > THR_W + 1) ? DW + 1 : THR_W + 2;

  logic signed [PW-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic signed [DW-1:0] delta_x_q, delta_x_d, delta_y_q, delta_y_d;
  logic [3:0][HOLD_W-1:0] hold_q, hold_d;
  logic [3:0][HOLD_W-1:0] c_dec, c_l, c_r, c_u, c_d;

  logic accept, frame_ok, key;
  logic fire_l, fire_r, fire_u, fire_d;
  logic signed [CW-1:0] dxe, dye, thr_l_n, thr_r_e, thr_u_n, thr_d_e;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign frame_ok   = !pos_x_i[PW-1] && !pos_y_i[PW-1];
  assign key        = !cfg_i.move_mode;

  assign dxe     = CW'(delta_x_q);
  assign dye     = CW'(delta_y_q);
  assign thr_l_n = -$signed({{(CW-THR_W){1'b0}}, cfg_i.thr_left});
  assign thr_r_e =  $signed({{(CW-THR_W){1'b0}}, cfg_i.thr_right});
  assign thr_u_n = -$signed({{(CW-THR_W){1'b0}}, cfg_i.thr_up});
  assign thr_d_e =  $signed({{(CW-THR_W){1'b0}}, cfg_i.thr_down});

  // Count down, then test left, right, up, down with later writes winning
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      c_dec[i] = (hold_q[i] == '0) ? '0 : hold_q[i] - 1'b1;
    end

    fire_l = frame_ok && (dxe < thr_l_n) && (c_dec[CNT_LEFT] == '0);
    c_l = c_dec;
    if (fire_l) begin
      if (key) begin
        c_l[CNT_UP]   = cfg_i.hold_long;
        c_l[CNT_DOWN] = cfg_i.hold_long;
      end
      c_l[CNT_LEFT]  = cfg_i.hold_short;
      c_l[CNT_RIGHT] = cfg_i.hold_long;
    end

    fire_r = frame_ok && (dxe > thr_r_e) && (c_l[CNT_RIGHT] == '0);
    c_r = c_l;
    if (fire_r) begin
      if (key) begin
        c_r[CNT_UP]   = cfg_i.hold_long;
        c_r[CNT_DOWN] = cfg_i.hold_long;
      end
      c_r[CNT_LEFT]  = cfg_i.hold_long;
      c_r[CNT_RIGHT] = cfg_i.hold_short;
    end

    fire_u = frame_ok && (dye < thr_u_n) && (c_r[CNT_UP] == '0);
    c_u = c_r;
    if (fire_u) begin
      if (key) begin
        c_u[CNT_LEFT]  = cfg_i.hold_long;
        c_u[CNT_RIGHT] = cfg_i.hold_long;
      end
      c_u[CNT_UP]   = cfg_i.hold_short;
      c_u[CNT_DOWN] = cfg_i.hold_long;
    end

    fire_d = frame_ok && (dye > thr_d_e) && (c_u[CNT_DOWN] == '0);
    c_d = c_u;
    if (fire_d) begin
      if (key) begin
        c_d[CNT_LEFT]  = cfg_i.hold_long;
        c_d[CNT_RIGHT] = cfg_i.hold_long;
      end
      c_d[CNT_UP]   = cfg_i.hold_long;
      c_d[CNT_DOWN] = cfg_i.hold_short;
    end
  end

  // Next state: counters on every frame, position and deltas on valid ones
  always_comb begin
    hold_d    = hold_q;
    prev_x_d  = prev_x_q;
    prev_y_d  = prev_y_q;
    delta_x_d = delta_x_q;
    delta_y_d = delta_y_q;
    if (accept) begin
      hold_d = c_d;
      if (frame_ok) begin
        delta_x_d = DW'(prev_x_q) - DW'(pos_x_i);
        delta_y_d = DW'(pos_y_i) - DW'(prev_y_q);
        prev_x_d  = pos_x_i;
        prev_y_d  = pos_y_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q    <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      delta_x_q <= '0;
      delta_y_q <= '0;
    end else begin
      hold_q    <= hold_d;
      prev_x_q  <= prev_x_d;
      prev_y_q  <= prev_y_d;
      delta_x_q <= delta_x_d;
      delta_y_q <= delta_y_d;
    end
  end

  // Describe the frame's events for the drain side
  always_comb begin
    push_ctl_o.slot_mask = {(fire_u || fire_d) && key, fire_u || fire_d,
                            (fire_l || fire_r) && key, fire_l || fire_r};
    push_ctl_o.x_right   = fire_r;
    push_ctl_o.y_down    = fire_d;
    push_ctl_o.key_mode  = key;
  end

  assign push_o    = accept && (fire_l || fire_r || fire_u || fire_d);
  assign push_dx_o = delta_x_q;
  assign push_dy_o = delta_y_q;

endmodule

[rtl/mgd_back.sv]
// Event drain: expands queued frame descriptors into press/release events.
// Depends on mgd_pkg; scales moves and holds the output register.
module mgd_back #(
  parameter int POS_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [mgd_pkg::GAIN_W-1:0]          move_gain_i,
  input  logic                                q_empty_i,
  input  mgd_pkg::ev_ctl_t                    head_ctl_i,
  input  logic signed [POS_BITS+1:0]          head_dx_i,
  input  logic signed [POS_BITS+1:0]          head_dy_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                action_o,
  output logic [1:0]                          direction_o,
  output logic [mgd_pkg::MOVE_W-1:0]          move_x_o,
  output logic [mgd_pkg::MOVE_W-1:0]          move_y_o,
  output logic                                last_o
);
  import mgd_pkg::*;

  localparam int DW = POS_BITS + 2;
  localparam int MW = (DW + GAIN_W + 1 > MOVE_W) ? DW + GAIN_W + 1 : MOVE_W;

  logic [3:0] done_q, done_d;
  logic [3:0] rem, sel;
  logic [1:0] slot;
  logic       load, final_ev;

  logic signed [MW-1:0] gain_e, prod_x, prod_y;

  logic              valid_q;
  logic              action_q;
  logic [1:0]        dir_q;
  logic [MOVE_W-1:0] mx_q, my_q;
  logic              last_q;

  // Pick the lowest pending slot of the head descriptor
  always_comb begin
    rem = head_ctl_i.slot_mask & ~done_q;
    if (rem[0]) begin
      slot = SLOT_X_PRESS;
    end else if (rem[1]) begin
      slot = SLOT_X_RELEASE;
    end else if (rem[2]) begin
      slot = SLOT_Y_PRESS;
    end else begin
      slot = SLOT_Y_RELEASE;
    end
    sel = 4'b0001 << slot;
  end

  assign load     = !q_empty_i && (!valid_q || out_ready_i);
  assign final_ev = ((rem & ~sel) == '0);
  assign pop_o    = load && final_ev;

  always_comb begin
    done_d = done_q;
    if (load) begin
      done_d = final_ev ? '0 : (done_q | sel);
    end
  end

  // Scale deltas by the gain; low bits wrap as in the event format
  assign gain_e = $signed({{(MW-GAIN_W){1'b0}}, move_gain_i});
  assign prod_x = $signed({{(MW-DW){head_dx_i[DW-1]}}, head_dx_i}) * gain_e;
  assign prod_y = $signed({{(MW-DW){head_dy_i[DW-1]}}, head_dy_i}) * gain_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Load the output register with the selected event
  always_ff @(posedge clk_i) begin
    if (load) begin
      last_q <= final_ev;
      mx_q   <= NO_MOVE;
      my_q   <= NO_MOVE;
      case (slot)
        SLOT_X_PRESS: begin
          action_q <= ACT_PRESS;
          dir_q    <= head_ctl_i.x_right ? DIR_RIGHT : DIR_LEFT;
          if (!head_ctl_i.key_mode) begin
            mx_q <= prod_x[MOVE_W-1:0];
          end
        end
        SLOT_X_RELEASE: begin
          action_q <= ACT_RELEASE;
          dir_q    <= head_ctl_i.x_right ? DIR_RIGHT : DIR_LEFT;
        end
        SLOT_Y_PRESS: begin
          action_q <= ACT_PRESS;
          dir_q    <= head_ctl_i.y_down ? DIR_DOWN : DIR_UP;
          if (!head_ctl_i.key_mode) begin
            my_q <= prod_y[MOVE_W-1:0];
          end
        end
        default: begin
          action_q <= ACT_RELEASE;
          dir_q    <= head_ctl_i.y_down ? DIR_DOWN : DIR_UP;
        end
      endcase
    end
  end

  assign out_valid_o = valid_q;
  assign action_o    = action_q;
  assign direction_o = dir_q;
  assign move_x_o    = mx_q;
  assign move_y_o    = my_q;
  assign last_o      = last_q;

endmodule

[rtl/motion_gesture_detector.sv]
// A frame enters the four-entry event queue when taken; its first event is
// loaded into the output register once that register is free, and the rest
// follow one per cycle while m_axis_tready is high. Throughput: a frame is
// taken every cycle while the event queue has room, and a frame yields at
// most four events. Reset clears positions, deltas, hold-off counters and
// the queue, and loads the register defaults; no clearing pass.
// Top level: configuration registers, mgd_front, mgd_fifo and mgd_back.
module motion_gesture_detector #(
  parameter int POS_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mgd_pkg::CFG_IW-1:0]       cfg_index_i,
  input  logic [mgd_pkg::CFG_DW-1:0]       cfg_data_i,
  // Frame stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata from bit 0: pos_x, pos_y, zero fill
  input  logic [((2*(POS_BITS+1)+7)/8)*8-1:0] s_axis_tdata,
  // Event stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata from bit 0: direction, move_x, move_y, zero fill
  output logic [47:0]                      m_axis_tdata,
  // tuser: action
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast
);
  import mgd_pkg::*;

  localparam int PW    = POS_BITS + 1;
  localparam int DW    = POS_BITS + 2;
  localparam int QW    = CTL_W + 2 * DW;
  localparam int OUT_W = 2 + 2 * MOVE_W;

  cfg_t cfg_q;

  logic               push, pop, q_full, q_empty;
  ev_ctl_t            push_ctl, head_ctl;
  logic signed [DW-1:0] push_dx, push_dy, head_dx, head_dy;
  logic [QW-1:0]      q_head;

  logic               action;
  logic [1:0]         direction;
  logic [MOVE_W-1:0]  move_x, move_y;

  // Write configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr_left   <= RST_THR_X;
      cfg_q.thr_right  <= RST_THR_X;
      cfg_q.thr_up     <= RST_THR_Y;
      cfg_q.thr_down   <= RST_THR_Y;
      cfg_q.hold_short <= RST_HOLD_SHORT;
      cfg_q.hold_long  <= RST_HOLD_LONG;
      cfg_q.move_gain  <= RST_MOVE_GAIN;
      cfg_q.move_mode  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_THR_LEFT:   cfg_q.thr_left   <= cfg_data_i[THR_W-1:0];
        REG_THR_RIGHT:  cfg_q.thr_right  <= cfg_data_i[THR_W-1:0];
        REG_THR_UP:     cfg_q.thr_up     <= cfg_data_i[THR_W-1:0];
        REG_THR_DOWN:   cfg_q.thr_down   <= cfg_data_i[THR_W-1:0];
        REG_HOLD_SHORT: cfg_q.hold_short <= cfg_data_i[HOLD_W-1:0];
        REG_HOLD_LONG:  cfg_q.hold_long  <= cfg_data_i[HOLD_W-1:0];
        REG_MOVE_GAIN:  cfg_q.move_gain  <= cfg_data_i[GAIN_W-1:0];
        REG_MOVE_MODE:  cfg_q.move_mode  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  mgd_front #(
    .POS_BITS (POS_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .pos_x_i    (s_axis_tdata[PW-1:0]),
    .pos_y_i    (s_axis_tdata[2*PW-1:PW]),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_ctl_o (push_ctl),
    .push_dx_o  (push_dx),
    .push_dy_o  (push_dy)
  );

  mgd_fifo #(
    .W (QW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_ctl, push_dx, push_dy}),
    .pop_i       (pop),
    .head_o      (q_head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  assign head_ctl = q_head[QW-1 -: CTL_W];
  assign head_dx  = q_head[2*DW-1:DW];
  assign head_dy  = q_head[DW-1:0];

  mgd_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .move_gain_i (cfg_q.move_gain),
    .q_empty_i   (q_empty),
    .head_ctl_i  (head_ctl),
    .head_dx_i   (head_dx),
    .head_dy_i   (head_dy),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .action_o    (action),
    .direction_o (direction),
    .move_x_o    (move_x),
    .move_y_o    (move_y),
    .last_o      (m_axis_tlast)
  );

  // Pack the event onto the stream
  assign m_axis_tdata = {{(48-OUT_W){1'b0}}, move_y, move_x, direction};
  assign m_axis_tuser = action;

endmodule

[bench/tb_top.sv]
// Self-checking bench for motion_gesture_detector: streams tracked positions, predicts the
// press/release/move events per frame and compares them with the event stream.
// Depends on mgd_pkg and the motion_gesture_detector RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mgd_pkg::*;

  localparam int POS_BITS    = 12;
  localparam int POS_W       = POS_BITS + 1;
  localparam int POS_MAX     = (1 << POS_BITS) - 1;
  localparam int TDATA_W     = ((2 * POS_W + 7) / 8) * 8;
  localparam int SETTLE_CYC  = 8;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
  } pos_frame_t;

  typedef struct packed {
    logic              action;
    logic [1:0]        dir;
    logic [MOVE_W-1:0] mx;
    logic [MOVE_W-1:0] my;
    logic              last;
  } gest_ev_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IW-1:0]    cfg_index_i = '0;
  logic [CFG_DW-1:0]    cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [47:0]          m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  // Frames waiting to be sent and events still owed by the block
  pos_frame_t frame_q[$];
  gest_ev_t   pending_events[$];
  int         fail_count = 0;

  // Predicted block state
  cfg_t                    regs;
  logic signed [POS_W-1:0] seen_x = '0;
  logic signed [POS_W-1:0] seen_y = '0;
  logic signed [POS_W:0]   step_x = '0;
  logic signed [POS_W:0]   step_y = '0;
  logic [HOLD_W-1:0]       hold_cnt [4];

  // Stimulus and handshake pacing
  int         walk_x, walk_y;
  pos_frame_t cur_frame;
  int         tx_hold = 0;
  int         rx_hold = 0;
  bit         tx_fast = 1'b0;
  bit         rx_fast = 1'b0;

  motion_gesture_detector #(
    .POS_BITS(POS_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic void note_fail(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
  endfunction

  // Pause length per transaction; flip between busy stretches and gap-free bursts
  function automatic int draw_pause(ref bit fast);
    if ($urandom_range(0, 15) == 0) fast = !fast;
    if (fast) return 0;
    return int'($urandom_range(0, 19));
  endfunction

  function automatic gest_ev_t mk_event(input logic act, input logic [1:0] dir,
                                        input logic [MOVE_W-1:0] mx,
                                        input logic [MOVE_W-1:0] my);
    gest_ev_t ev;
    ev.action = act;
    ev.dir    = dir;
    ev.mx     = mx;
    ev.my     = my;
    ev.last   = 1'b0;
    return ev;
  endfunction

  // Mirror one register write into the predicted configuration
  function automatic void apply_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    case (idx)
      REG_THR_LEFT:   regs.thr_left   = val[THR_W-1:0];
      REG_THR_RIGHT:  regs.thr_right  = val[THR_W-1:0];
      REG_THR_UP:     regs.thr_up     = val[THR_W-1:0];
      REG_THR_DOWN:   regs.thr_down   = val[THR_W-1:0];
      REG_HOLD_SHORT: regs.hold_short = val[HOLD_W-1:0];
      REG_HOLD_LONG:  regs.hold_long  = val[HOLD_W-1:0];
      REG_MOVE_GAIN:  regs.move_gain  = val[GAIN_W-1:0];
      REG_MOVE_MODE:  regs.move_mode  = val[0];
      default: ;
    endcase
  endfunction

  // Work out the events one accepted frame causes and advance the predicted state
  function automatic void predict_gestures(input pos_frame_t f);
    gest_ev_t          evs[$];
    int                dx, dy, mvx, mvy;
    logic [MOVE_W-1:0] mx_v, my_v;
    bit                key;
    for (int i = 0; i < 4; i++) begin
      if (hold_cnt[i] != '0) hold_cnt[i] = hold_cnt[i] - 1'b1;
    end
    // lost object: counters still run down, nothing else moves
    if (f.x[POS_W-1] || f.y[POS_W-1]) return;

    key  = (regs.move_mode == 1'b0);
    dx   = int'(step_x);
    dy   = int'(step_y);
    mvx  = key ? -1 : dx * int'(regs.move_gain);
    mvy  = key ? -1 : dy * int'(regs.move_gain);
    mx_v = MOVE_W'(mvx);
    my_v = MOVE_W'(mvy);

    if (dx < -int'(regs.thr_left) && hold_cnt[CNT_LEFT] == '0) begin
      evs.push_back(mk_event(ACT_PRESS, DIR_LEFT, mx_v, NO_MOVE));
      if (key) begin
        evs.push_back(mk_event(ACT_RELEASE, DIR_LEFT, NO_MOVE, NO_MOVE));
        hold_cnt[CNT_UP]   = regs.hold_long;
        hold_cnt[CNT_DOWN] = regs.hold_long;
      end
      hold_cnt[CNT_LEFT]  = regs.hold_short;
      hold_cnt[CNT_RIGHT] = regs.hold_long;
    end
    if (dx > int'(regs.thr_right) && hold_cnt[CNT_RIGHT] == '0) begin
      evs.push_back(mk_event(ACT_PRESS, DIR_RIGHT, mx_v, NO_MOVE));
      if (key) begin
        evs.push_back(mk_event(ACT_RELEASE, DIR_RIGHT, NO_MOVE, NO_MOVE));
        hold_cnt[CNT_UP]   = regs.hold_long;
        hold_cnt[CNT_DOWN] = regs.hold_long;
      end
      hold_cnt[CNT_LEFT]  = regs.hold_long;
      hold_cnt[CNT_RIGHT] = regs.hold_short;
    end
    if (dy < -int'(regs.thr_up) && hold_cnt[CNT_UP] == '0) begin
      evs.push_back(mk_event(ACT_PRESS, DIR_UP, NO_MOVE, my_v));
      if (key) begin
        evs.push_back(mk_event(ACT_RELEASE, DIR_UP, NO_MOVE, NO_MOVE));
        hold_cnt[CNT_LEFT]  = regs.hold_long;
        hold_cnt[CNT_RIGHT] = regs.hold_long;
      end
      hold_cnt[CNT_UP]   = regs.hold_short;
      hold_cnt[CNT_DOWN] = regs.hold_long;
    end
    if (dy > int'(regs.thr_down) && hold_cnt[CNT_DOWN] == '0) begin
      evs.push_back(mk_event(ACT_PRESS, DIR_DOWN, NO_MOVE, my_v));
      if (key) begin
        evs.push_back(mk_event(ACT_RELEASE, DIR_DOWN, NO_MOVE, NO_MOVE));
        hold_cnt[CNT_LEFT]  = regs.hold_long;
        hold_cnt[CNT_RIGHT] = regs.hold_long;
      end
      hold_cnt[CNT_UP]   = regs.hold_long;
      hold_cnt[CNT_DOWN] = regs.hold_short;
    end

    // x delta is mirrored, y delta is not; both are tested on the next valid frame
    step_x = (POS_W+1)'(int'(seen_x) - int'(f.x));
    step_y = (POS_W+1)'(int'(f.y) - int'(seen_y));
    seen_x = f.x;
    seen_y = f.y;

    if (evs.size() != 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[i]) pending_events.push_back(evs[i]);
  endfunction

  // Frame driver: predict on each transaction, then pause or present the next frame
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_hold = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_gestures(cur_frame);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_hold > 0) begin
          tx_hold--;
          s_axis_tvalid <= 1'b0;
        end else if (frame_q.size() != 0) begin
          cur_frame = frame_q.pop_front();
          s_axis_tdata  <= TDATA_W'(cur_frame);
          s_axis_tvalid <= 1'b1;
          tx_hold = draw_pause(tx_fast);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Event monitor: check each transaction against the oldest owed event, stall at random
  always @(posedge clk_i) begin
    gest_ev_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.action = m_axis_tuser;
        got.dir    = m_axis_tdata[1:0];
        got.mx     = m_axis_tdata[2 +: MOVE_W];
        got.my     = m_axis_tdata[2 + MOVE_W +: MOVE_W];
        got.last   = m_axis_tlast;
        if (pending_events.size() == 0) begin
          note_fail($sformatf("unexpected event act=%0b dir=%0d mx=%h my=%h last=%0b",
                              got.action, got.dir, got.mx, got.my, got.last));
        end else begin
          want = pending_events.pop_front();
          if (got.action !== want.action || got.dir !== want.dir || got.mx !== want.mx ||
              got.my !== want.my || got.last !== want.last) begin
            note_fail($sformatf({"event mismatch: exp act=%0b dir=%0d mx=%h my=%h last=%0b,",
                                 " got act=%0b dir=%0d mx=%h my=%h last=%0b"},
                                want.action, want.dir, want.mx, want.my, want.last,
                                got.action, got.dir, got.mx, got.my, got.last));
          end
        end
        rx_hold = draw_pause(rx_fast);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic void add_frame(input int x, input int y);
    pos_frame_t f;
    f.x = POS_W'(x);
    f.y = POS_W'(y);
    frame_q.push_back(f);
  endfunction

  function automatic int clamp_pos(input int v);
    return (v < 0) ? 0 : ((v > POS_MAX) ? POS_MAX : v);
  endfunction

  // Random hand track: swipes and jitter, with jumps and lost-object frames mixed in
  task automatic queue_track(input int n);
    int r, step, jit;
    repeat (n) begin
      r   = $urandom_range(0, 99);
      jit = int'($urandom_range(0, 24)) - 12;
      if (r < 8) begin
        case ($urandom_range(0, 3))
          0:       add_frame(-1, walk_y);
          1:       add_frame(walk_x, -1);
          2:       add_frame(-1, -1);
          default: add_frame(-int'($urandom_range(1, 1 << POS_BITS)), walk_y);
        endcase
      end else begin
        if (r < 14) begin
          walk_x = $urandom_range(0, POS_MAX);
          walk_y = $urandom_range(0, POS_MAX);
        end else if (r < 55) begin
          step = $urandom_range(15, 400);
          if ($urandom_range(0, 1)) step = -step;
          if ($urandom_range(0, 1)) begin
            walk_x += step;
            walk_y += jit;
          end else begin
            walk_x += jit;
            walk_y += step;
          end
        end else begin
          walk_x += jit;
          walk_y += int'($urandom_range(0, 24)) - 12;
        end
        walk_x = clamp_pos(walk_x);
        walk_y = clamp_pos(walk_y);
        add_frame(walk_x, walk_y);
      end
    end
  endtask

  // Block until every frame is sent and every owed event has arrived, then let it settle
  task automatic wait_drained();
    do @(negedge clk_i);
    while (frame_q.size() != 0 || s_axis_tvalid || pending_events.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic set_regs(input int thl, input int thr, input int thu, input int thd,
                          input int hs, input int hl, input int gain, input int mode);
    write_reg(REG_THR_LEFT, CFG_DW'(thl));
    write_reg(REG_THR_RIGHT, CFG_DW'(thr));
    write_reg(REG_THR_UP, CFG_DW'(thu));
    write_reg(REG_THR_DOWN, CFG_DW'(thd));
    write_reg(REG_HOLD_SHORT, CFG_DW'(hs));
    write_reg(REG_HOLD_LONG, CFG_DW'(hl));
    write_reg(REG_MOVE_GAIN, CFG_DW'(gain));
    write_reg(REG_MOVE_MODE, CFG_DW'(mode));
  endtask

  initial begin
    regs.thr_left   = RST_THR_X;
    regs.thr_right  = RST_THR_X;
    regs.thr_up     = RST_THR_Y;
    regs.thr_down   = RST_THR_Y;
    regs.hold_short = RST_HOLD_SHORT;
    regs.hold_long  = RST_HOLD_LONG;
    regs.move_gain  = RST_MOVE_GAIN;
    regs.move_mode  = 1'b0;
    for (int i = 0; i < 4; i++) hold_cnt[i] = '0;
    walk_x = POS_MAX / 2;
    walk_y = POS_MAX / 2;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults, key mode: first valid frame, lost objects of several kinds
    add_frame(POS_MAX, POS_MAX);
    add_frame(POS_MAX, POS_MAX);
    add_frame(-1, 0);
    add_frame(0, -1);
    add_frame(-(1 << POS_BITS), -(1 << POS_BITS));
    add_frame(0, 0);
    add_frame(0, 0);
    queue_track(30);
    wait_drained();

    // Key mode with zero thresholds and no hold-off: both axes can fire, up to four events a frame
    set_regs(0, 0, 0, 0, 0, 0, 0, 0);
    add_frame(2000, 2000);
    add_frame(1000, 3000);
    add_frame(3000, 1000);
    add_frame(3000, 1000);
    queue_track(25);
    wait_drained();

    // Move mode at full gain over full-range swings
    set_regs(0, 0, 0, 0, 0, 0, 255, 1);
    add_frame(0, 0);
    add_frame(POS_MAX, POS_MAX);
    add_frame(0, 0);
    add_frame(0, 0);
    queue_track(25);
    wait_drained();

    // Unreachable thresholds, longest holds, zero gain
    set_regs(POS_MAX, POS_MAX, POS_MAX, POS_MAX, 65535, 65535, 0, 1);
    queue_track(15);
    wait_drained();

    // Key mode: a detected direction stays blocked for the longest hold
    set_regs(10, 10, 10, 10, 65535, 0, 7, 0);
    queue_track(15);
    wait_drained();

    // Random settings
    repeat (2) begin
      set_regs($urandom_range(0, 60), $urandom_range(0, 60), $urandom_range(0, 60),
               $urandom_range(0, 60), $urandom_range(0, 8), $urandom_range(0, 20),
               $urandom_range(0, 255), $urandom_range(0, 1));
      queue_track(25);
      wait_drained();
    end

    if (fail_count == 0 && pending_events.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
rtl/mgd_pkg.sv
rtl/mgd_fifo.sv
rtl/mgd_front.sv
rtl/mgd_back.sv
rtl/motion_gesture_detector.sv
bench/tb_top.sv
